// ===== rtl/glmf_pkg.sv =====
// ----------------------------------------------------------------------------
// glmf_pkg
// Shared types and constants of the grid local maximum finder.
// ----------------------------------------------------------------------------
package glmf_pkg;

  // configuration port
  localparam int CFG_W         = 6;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DIM_RESET = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS = 1'b0,
    REG_GRID_COLS = 1'b1
  } cfg_reg_t;

  // result coordinate width
  localparam int OUT_W = 5;

  // result queue, one entry per input item with at least one peak
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = 2;
  localparam int OQ_CNT_W = 3;

  // bit positions in a hit mask, in result order
  localparam int HIT_ABOVE = 0;  // cell one row up, same column
  localparam int HIT_LEFT  = 1;  // last row, cell one column left
  localparam int HIT_HERE  = 2;  // last row and last column, the item itself
  localparam int HIT_N     = 3;

  // neighbour presence for the item at (r, c)
  typedef struct packed {
    logic has_up;     // r > 0
    logic has_up2;    // r > 1
    logic last_row;
    logic has_left;   // c > 0
    logic has_left2;  // c > 1
    logic last_col;
  } win_flags_t;

  typedef struct packed {
    logic [OUT_W-1:0] row;
    logic [OUT_W-1:0] col;
    logic [HIT_N-1:0] hits;
  } peak_item_t;

endpackage

// ===== rtl/grid_local_maximum_finder_unit.sv =====
// ----------------------------------------------------------------------------
// grid_local_maximum_finder_unit
// Streams a grid in raster order and reports every cell that is not smaller
// than any of its up, down, left and right neighbours.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid, in_stall, in_cell_value       | sink
//   out     | out_valid, out_stall, out_peak_row/col, | source
//           | out_run_last                            |
//   cfg     | cfg_wr_en, cfg_index, cfg_wdata         | sink
//
// One item per clock sustained while in_stall is low; results leave one per
// clock while out_stall is low, so only the last row (up to three results
// per item) runs at the output rate. The accept cycle writes the line store
// and reads the next column; the compare stage then pushes into a four-entry
// result queue. in_stall rises when that queue holds three or more entries.
// Reset is synchronous and needs no clearing pass; stale line store data is
// read only where the neighbour flags mask it out.
// ----------------------------------------------------------------------------
module grid_local_maximum_finder_unit #(
  parameter int MAX_DIM    = 32,
  parameter int VALUE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VALUE_BITS-1:0]  in_cell_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [glmf_pkg::OUT_W-1:0]    out_peak_row,
  output logic [glmf_pkg::OUT_W-1:0]    out_peak_col,
  output logic                          out_run_last,
  input  logic                          cfg_wr_en,
  input  logic [glmf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [glmf_pkg::CFG_W-1:0]    cfg_wdata
);
  import glmf_pkg::*;

  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int LW    = 2 * VALUE_BITS;

  function automatic logic [IDX_W-1:0] dim_last(input logic [CFG_W-1:0] raw);
    if (raw == '0) begin
      return '0;
    end
    if (int'(raw) > MAX_DIM) begin
      return IDX_W'(MAX_DIM - 1);
    end
    return IDX_W'(raw - CFG_W'(1));
  endfunction

  logic [IDX_W-1:0]             rows_last_r;
  logic [IDX_W-1:0]             cols_last_r;
  logic [IDX_W-1:0]             row_r;
  logic [IDX_W-1:0]             row_nxt;
  logic [IDX_W-1:0]             col_r;
  logic [IDX_W-1:0]             col_nxt;
  logic                         acc;
  win_flags_t                   flags;
  logic [IDX_W-1:0]             rd_addr;
  logic [LW-1:0]                ram_q;
  logic [LW-1:0]                ahead;
  logic [LW-1:0]                wr_data;
  logic                         byp_r;
  logic [LW-1:0]                byp_data_r;
  logic signed [VALUE_BITS-1:0] u1;
  logic signed [VALUE_BITS-1:0] u2;
  logic signed [VALUE_BITS-1:0] cur1_r;
  logic signed [VALUE_BITS-1:0] cur2_r;
  logic signed [VALUE_BITS-1:0] upl_r;
  logic                         push_valid;
  peak_item_t                   push_item;
  logic                         full_stall;

  assign in_stall = full_stall;
  assign acc      = in_valid && !in_stall;

  // entry c holds {row r-1, row r-2} of column c while row r streams in
  assign ahead   = byp_r ? byp_data_r : ram_q;
  assign u1      = ahead[LW-1:VALUE_BITS];
  assign u2      = ahead[VALUE_BITS-1:0];
  assign wr_data = {in_cell_value, u1};

  always_comb begin
    flags.has_up    = (row_r != '0);
    flags.has_up2   = (row_r > IDX_W'(1));
    flags.last_row  = (row_r == rows_last_r);
    flags.has_left  = (col_r != '0);
    flags.has_left2 = (col_r > IDX_W'(1));
    flags.last_col  = (col_r == cols_last_r);
  end

  // fetch the next column ahead; at row end, wrap to column 0
  assign rd_addr = flags.last_col ? '0 : col_r + IDX_W'(1);

  glmf_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_DIM)
  ) u_line (
    .clk     (clk),
    .wr_en   (acc),
    .wr_addr (col_r),
    .wr_data (wr_data),
    .rd_en   (acc),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cfg_wr_en) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (acc) begin
      if (flags.last_col) begin
        col_nxt = '0;
        row_nxt = flags.last_row ? '0 : row_r + IDX_W'(1);
      end else begin
        col_nxt = col_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_last_r <= dim_last(CFG_W'(CFG_DIM_RESET));
      cols_last_r <= dim_last(CFG_W'(CFG_DIM_RESET));
      row_r       <= '0;
      col_r       <= '0;
      byp_r       <= 1'b0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_GRID_ROWS: rows_last_r <= dim_last(cfg_wdata);
          REG_GRID_COLS: cols_last_r <= dim_last(cfg_wdata);
          default: ;
        endcase
      end
      if (acc) begin
        // same entry written and read: forward the write
        byp_r <= (rd_addr == col_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      byp_data_r <= wr_data;
      cur1_r     <= in_cell_value;
      cur2_r     <= cur1_r;
      upl_r      <= u1;
    end
  end

  glmf_eval #(
    .VALUE_BITS (VALUE_BITS),
    .IDX_W      (IDX_W)
  ) u_eval (
    .clk        (clk),
    .rst_n      (rst_n),
    .a_valid    (acc),
    .a_flags    (flags),
    .a_row      (row_r),
    .a_col      (col_r),
    .a_v        (in_cell_value),
    .a_u1       (u1),
    .a_u2       (u2),
    .a_l1       (upl_r),
    .a_c1       (cur1_r),
    .a_c2       (cur2_r),
    .b_r1       (u1),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  glmf_outq u_outq (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_valid   (push_valid),
    .push_item    (push_item),
    .full_stall   (full_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_peak_row (out_peak_row),
    .out_peak_col (out_peak_col),
    .out_run_last (out_run_last)
  );

endmodule

// ===== rtl/glmf_ram.sv =====
// ----------------------------------------------------------------------------
// glmf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module glmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/glmf_eval.sv =====
// ----------------------------------------------------------------------------
// glmf_eval
// Compare stage: holds one accepted item with its neighbour window and
// decides which of the up to three candidate cells are peaks.
// ----------------------------------------------------------------------------
module glmf_eval #(
  parameter int VALUE_BITS = 16,
  parameter int IDX_W      = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          a_valid,
  input  glmf_pkg::win_flags_t          a_flags,
  input  logic [IDX_W-1:0]              a_row,
  input  logic [IDX_W-1:0]              a_col,
  input  logic signed [VALUE_BITS-1:0]  a_v,
  input  logic signed [VALUE_BITS-1:0]  a_u1,
  input  logic signed [VALUE_BITS-1:0]  a_u2,
  input  logic signed [VALUE_BITS-1:0]  a_l1,
  input  logic signed [VALUE_BITS-1:0]  a_c1,
  input  logic signed [VALUE_BITS-1:0]  a_c2,
  input  logic signed [VALUE_BITS-1:0]  b_r1,
  output logic                          push_valid,
  output glmf_pkg::peak_item_t          push_item
);
  import glmf_pkg::*;

  logic                         b_valid_r;
  win_flags_t                   f_r;
  logic [IDX_W-1:0]             row_r;
  logic [IDX_W-1:0]             col_r;
  logic signed [VALUE_BITS-1:0] v_r;
  logic signed [VALUE_BITS-1:0] u1_r;
  logic signed [VALUE_BITS-1:0] u2_r;
  logic signed [VALUE_BITS-1:0] l1_r;
  logic signed [VALUE_BITS-1:0] c1_r;
  logic signed [VALUE_BITS-1:0] c2_r;
  logic [HIT_N-1:0]             hits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid) begin
      f_r   <= a_flags;
      row_r <= a_row;
      col_r <= a_col;
      v_r   <= a_v;
      u1_r  <= a_u1;
      u2_r  <= a_u2;
      l1_r  <= a_l1;
      c1_r  <= a_c1;
      c2_r  <= a_c2;
    end
  end

  // right neighbour of the upper cell arrives from the line store this cycle
  always_comb begin
    hits[HIT_ABOVE] = f_r.has_up && (u1_r >= v_r)
                      && (!f_r.has_up2 || u1_r >= u2_r)
                      && (!f_r.has_left || u1_r >= l1_r)
                      && (f_r.last_col || u1_r >= b_r1);
    hits[HIT_LEFT]  = f_r.last_row && f_r.has_left && (c1_r >= v_r)
                      && (!f_r.has_up || c1_r >= l1_r)
                      && (!f_r.has_left2 || c1_r >= c2_r);
    hits[HIT_HERE]  = f_r.last_row && f_r.last_col
                      && (!f_r.has_up || v_r >= u1_r)
                      && (!f_r.has_left || v_r >= c1_r);
  end

  assign push_valid     = b_valid_r && (hits != '0);
  assign push_item.row  = OUT_W'(row_r);
  assign push_item.col  = OUT_W'(col_r);
  assign push_item.hits = hits;

endmodule

// ===== rtl/glmf_outq.sv =====
// ----------------------------------------------------------------------------
// glmf_outq
// Result queue: one entry per item with peaks, unpacked into single
// results on the output channel.
// ----------------------------------------------------------------------------
module glmf_outq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push_valid,
  input  glmf_pkg::peak_item_t       push_item,
  output logic                       full_stall,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [glmf_pkg::OUT_W-1:0] out_peak_row,
  output logic [glmf_pkg::OUT_W-1:0] out_peak_col,
  output logic                       out_run_last
);
  import glmf_pkg::*;

  peak_item_t          q_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr_r;
  logic [OQ_PTR_W-1:0] rd_ptr_r;
  logic [OQ_CNT_W-1:0] count_r;
  logic [OQ_CNT_W-1:0] count_nxt;
  logic [HIT_N-1:0]    done_r;
  logic [HIT_N-1:0]    done_nxt;
  peak_item_t          head;
  logic [HIT_N-1:0]    rem;
  logic [HIT_N-1:0]    sel;
  logic                xfer;
  logic                pop;

  assign head      = q_r[rd_ptr_r];
  assign rem       = head.hits & ~done_r;
  assign out_valid = (count_r != '0);
  assign xfer      = out_valid && !out_stall;

  always_comb begin
    sel          = '0;
    out_peak_row = head.row;
    out_peak_col = head.col;
    if (rem[HIT_ABOVE]) begin
      sel[HIT_ABOVE] = 1'b1;
      out_peak_row   = head.row - OUT_W'(1);
    end else if (rem[HIT_LEFT]) begin
      sel[HIT_LEFT]  = 1'b1;
      out_peak_col   = head.col - OUT_W'(1);
    end else begin
      sel[HIT_HERE]  = 1'b1;
    end
  end

  assign out_run_last = ((rem & ~sel) == '0);
  assign pop          = xfer && out_run_last;

  // leave room for the item in the compare stage and one more
  assign full_stall = (count_r >= OQ_CNT_W'(OQ_DEPTH - 1));

  always_comb begin
    count_nxt = count_r;
    if (push_valid && !pop) begin
      count_nxt = count_r + OQ_CNT_W'(1);
    end else if (!push_valid && pop) begin
      count_nxt = count_r - OQ_CNT_W'(1);
    end
    done_nxt = done_r;
    if (pop) begin
      done_nxt = '0;
    end else if (xfer) begin
      done_nxt = done_r | sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      done_r   <= '0;
    end else begin
      count_r <= count_nxt;
      done_r  <= done_nxt;
      if (push_valid) begin
        wr_ptr_r <= wr_ptr_r + OQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + OQ_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      q_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/glmf_checker.sv =====
// ----------------------------------------------------------------------------
// glmf_checker
// Port-level checks of the grid local maximum finder, bound to the top.
// ----------------------------------------------------------------------------
module glmf_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [glmf_pkg::OUT_W-1:0] out_peak_row,
  input logic [glmf_pkg::OUT_W-1:0] out_peak_col,
  input logic                       out_run_last
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_peak_row)
      && $stable(out_peak_col) && $stable(out_run_last))
    else $error("stalled result changed");

  // results of one item leave without gaps
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_run_last |=> out_valid)
    else $error("result run broken");

  // backpressure only comes from pending results
  a_stall_cause: assert property (@(posedge clk)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind grid_local_maximum_finder_unit glmf_checker u_glmf_checker (.*);
